[hw/rtl/polygon_ear_clip_triangulator_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the polygon ear-clip triangulator
// Concurrent checks sampled on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef POLYGON_EAR_CLIP_TRIANGULATOR_MACROS_SVH
`define POLYGON_EAR_CLIP_TRIANGULATOR_MACROS_SVH

// same-cycle implication
`define PETC_ASSERT_NOW(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define PETC_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[hw/rtl/petc_pkg.sv]
// ----------------------------------------------------------------------------
// petc_pkg
// Shared constants and payload types of the polygon ear-clip triangulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package petc_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int COORD_WIDTH  = 16;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int DIFF_W       = COORD_WIDTH + 1;
	localparam int PROD_W       = 2 * DIFF_W;

	// scan stops once this many vertices remain
	localparam logic [CNT_W-1:0] CLIP_STOP = CNT_W'(2);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t vertex_x;
		coord_t vertex_y;
		logic   last_vertex;
	} vtx_t;

	typedef struct packed {
		coord_t tri_ax;
		coord_t tri_ay;
		coord_t tri_bx;
		coord_t tri_by;
		coord_t tri_cx;
		coord_t tri_cy;
		logic   tri_valid;
		logic   overflow;
		logic   last_triangle;
	} tri_t;

endpackage

[hw/rtl/petc_ram.sv]
// ----------------------------------------------------------------------------
// petc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module petc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/polygon_ear_clip_triangulator.sv]
// ----------------------------------------------------------------------------
// polygon_ear_clip_triangulator
// Loads polygon vertices and clips negative-turn ears into triangles.
//
// Vertices are taken one per cycle and written to the coordinate memories
// until the one marked last_vertex arrives; vertices beyond MAX_VERTICES are
// dropped and flagged in overflow. The block then stops taking vertices and
// scans the live list. Each candidate ear passes through a bookkeeping step,
// a chain of dependent reads (three ids from the live-order memory, each
// feeding a read of the coordinate memories), a difference, a multiply and a
// compare. A clipped ear adds a step to hand over the held triangle and a
// compaction of the live-order memory, one entry per cycle; each wrap of the
// cursor adds a check step. Closing the polygon takes a flush step, preceded
// by a check step when the scan ends on two or fewer live vertices. The
// hand-over and flush steps wait while the output register still holds an
// unaccepted result, the hand-over only when a triangle is already held. A
// triangle is held back until the next one is found so the final one can
// carry last_triangle; a polygon that yields nothing gives a single result
// with tri_valid low. The next polygon's vertices are taken as soon as the
// final result sits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polygon_ear_clip_triangulator import petc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic vtx_valid,
	output logic vtx_ready,
	input  vtx_t vtx,
	output logic res_valid,
	input  logic res_ready,
	output tri_t res
);

	localparam logic [3:0] S_LOAD  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_FETCH = 4'd2;
	localparam logic [3:0] S_DIFF  = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_CMP   = 4'd5;
	localparam logic [3:0] S_EMIT  = 4'd6;
	localparam logic [3:0] S_SHIFT = 4'd7;
	localparam logic [3:0] S_FLUSH = 4'd8;

	// fetch steps: ids go out on 0..2, coordinates come back on 2..4
	localparam logic [2:0] FETCH_P0   = 3'd0;
	localparam logic [2:0] FETCH_P1   = 3'd1;
	localparam logic [2:0] FETCH_A    = 3'd2;
	localparam logic [2:0] FETCH_B    = 3'd3;
	localparam logic [2:0] FETCH_LAST = 3'd4;

	logic [3:0]       state_q;
	logic [2:0]       step_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cursor_q;
	logic [CNT_W-1:0] pass_q;
	logic             ovf_q;
	logic             pend_v_q;
	logic             out_v_q;
	logic [CNT_W-1:0] shift_k_q;
	logic             shift_v_s1;
	logic [IDX_W-1:0] shift_wa_s1;

	logic [IDX_W-1:0] p0_q, p1_q, p2_q;
	coord_t           ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic signed [DIFF_W-1:0] ux_q, uy_q, vx_q, vy_q;
	logic signed [PROD_W-1:0] m1_q, m2_q;
	tri_t             pend_q;
	tri_t             out_q;

	logic             vtx_acc;
	logic             out_free;
	logic             store_we;
	logic [IDX_W-1:0] load_addr;
	logic             ord_we;
	logic [IDX_W-1:0] ord_waddr;
	logic [IDX_W-1:0] ord_wdata;
	logic [IDX_W-1:0] ord_raddr;
	logic [IDX_W-1:0] ord_rdata;
	logic [COORD_WIDTH-1:0] x_rd, y_rd;
	logic [CNT_W-1:0] c1, c2, p1w, p2w;
	logic [CNT_W-1:0] shift_nxt;
	logic             neg;
	logic             emit_go;
	logic             out_load;
	tri_t             out_nxt;
	tri_t             cur_tri;

	assign vtx_ready = (state_q == S_LOAD);
	assign vtx_acc   = vtx_valid && vtx_ready;
	assign out_free  = !out_v_q || res_ready;
	assign store_we  = vtx_acc && (count_q < CNT_W'(MAX_VERTICES));
	assign load_addr = count_q[IDX_W-1:0];

	// positions of the next two vertices, wrapped on the live count
	assign c1  = cursor_q + CNT_W'(1);
	assign p1w = (c1 >= count_q) ? c1 - count_q : c1;
	assign c2  = p1w + CNT_W'(1);
	assign p2w = (c2 >= count_q) ? c2 - count_q : c2;

	assign shift_nxt = shift_k_q + CNT_W'(1);
	assign neg       = (m1_q < m2_q);
	assign emit_go   = (state_q == S_EMIT) && (!pend_v_q || out_free);

	// live-order memory: load writes identity, compaction moves k+1 to k
	assign ord_we    = store_we || shift_v_s1;
	assign ord_waddr = shift_v_s1 ? shift_wa_s1 : load_addr;
	assign ord_wdata = shift_v_s1 ? ord_rdata : load_addr;

	always_comb begin
		if (state_q == S_SHIFT) begin
			ord_raddr = shift_nxt[IDX_W-1:0];
		end else begin
			unique case (step_q)
				FETCH_P0: ord_raddr = p0_q;
				FETCH_P1: ord_raddr = p1_q;
				default:  ord_raddr = p2_q;
			endcase
		end
	end

	always_comb begin
		cur_tri               = '0;
		cur_tri.tri_ax        = ax_q;
		cur_tri.tri_ay        = ay_q;
		cur_tri.tri_bx        = bx_q;
		cur_tri.tri_by        = by_q;
		cur_tri.tri_cx        = cx_q;
		cur_tri.tri_cy        = cy_q;
		cur_tri.tri_valid     = 1'b1;
	end

	always_comb begin
		out_load              = 1'b0;
		out_nxt               = pend_q;
		out_nxt.overflow      = ovf_q;
		out_nxt.last_triangle = 1'b0;
		if (state_q == S_EMIT && pend_v_q && out_free) begin
			out_load = 1'b1;
		end
		if (state_q == S_FLUSH && out_free) begin
			out_load              = 1'b1;
			out_nxt.last_triangle = 1'b1;
			if (!pend_v_q) begin
				out_nxt               = '0;
				out_nxt.overflow      = ovf_q;
				out_nxt.last_triangle = 1'b1;
			end
		end
	end

	petc_ram #(.WIDTH(COORD_WIDTH), .DEPTH(MAX_VERTICES)) u_store_x (
		.clk   (clk),
		.we    (store_we),
		.waddr (load_addr),
		.wdata (vtx.vertex_x),
		.raddr (ord_rdata),
		.rdata (x_rd)
	);

	petc_ram #(.WIDTH(COORD_WIDTH), .DEPTH(MAX_VERTICES)) u_store_y (
		.clk   (clk),
		.we    (store_we),
		.waddr (load_addr),
		.wdata (vtx.vertex_y),
		.raddr (ord_rdata),
		.rdata (y_rd)
	);

	petc_ram #(.WIDTH(IDX_W), .DEPTH(MAX_VERTICES)) u_live_order (
		.clk   (clk),
		.we    (ord_we),
		.waddr (ord_waddr),
		.wdata (ord_wdata),
		.raddr (ord_raddr),
		.rdata (ord_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			step_q     <= FETCH_P0;
			count_q    <= '0;
			cursor_q   <= '0;
			pass_q     <= '0;
			ovf_q      <= 1'b0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			shift_k_q  <= '0;
			shift_v_s1 <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (res_ready) begin
				out_v_q <= 1'b0;
			end
			shift_v_s1 <= 1'b0;

			unique case (state_q)
				S_LOAD: begin
					if (vtx_acc) begin
						if (store_we) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (vtx.last_vertex) begin
							state_q  <= S_CHECK;
							cursor_q <= '0;
							pass_q   <= store_we ? count_q + CNT_W'(1) : count_q;
						end
					end
				end
				S_CHECK: begin
					if (count_q <= CLIP_STOP) begin
						state_q <= S_FLUSH;
					end else if (cursor_q >= count_q) begin
						// end of pass: stop if nothing was clipped
						cursor_q <= '0;
						if (count_q == pass_q) begin
							state_q <= S_FLUSH;
						end else begin
							pass_q <= count_q;
						end
					end else begin
						state_q <= S_FETCH;
						step_q  <= FETCH_P0;
					end
				end
				S_FETCH: begin
					step_q <= step_q + 3'd1;
					if (step_q == FETCH_LAST) begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: state_q <= S_MUL;
				S_MUL:  state_q <= S_CMP;
				S_CMP: begin
					if (neg) begin
						state_q <= S_EMIT;
					end else begin
						cursor_q <= cursor_q + CNT_W'(1);
						state_q  <= S_CHECK;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						pend_v_q  <= 1'b1;
						shift_k_q <= {1'b0, p1_q};
						state_q   <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (shift_nxt < count_q) begin
						shift_v_s1 <= 1'b1;
						shift_k_q  <= shift_nxt;
					end else if (!shift_v_s1) begin
						count_q  <= count_q - CNT_W'(1);
						cursor_q <= cursor_q + CNT_W'(1);
						state_q  <= S_CHECK;
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						count_q  <= '0;
						cursor_q <= '0;
						pass_q   <= '0;
						ovf_q    <= 1'b0;
						pend_v_q <= 1'b0;
						state_q  <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) begin
			p0_q <= cursor_q[IDX_W-1:0];
			p1_q <= p1w[IDX_W-1:0];
			p2_q <= p2w[IDX_W-1:0];
		end
		if (state_q == S_FETCH) begin
			unique case (step_q)
				FETCH_A: begin
					ax_q <= x_rd;
					ay_q <= y_rd;
				end
				FETCH_B: begin
					bx_q <= x_rd;
					by_q <= y_rd;
				end
				FETCH_LAST: begin
					cx_q <= x_rd;
					cy_q <= y_rd;
				end
				default: ;
			endcase
		end
		if (state_q == S_DIFF) begin
			ux_q <= {bx_q[COORD_WIDTH-1], bx_q} - {ax_q[COORD_WIDTH-1], ax_q};
			uy_q <= {by_q[COORD_WIDTH-1], by_q} - {ay_q[COORD_WIDTH-1], ay_q};
			vx_q <= {cx_q[COORD_WIDTH-1], cx_q} - {bx_q[COORD_WIDTH-1], bx_q};
			vy_q <= {cy_q[COORD_WIDTH-1], cy_q} - {by_q[COORD_WIDTH-1], by_q};
		end
		if (state_q == S_MUL) begin
			m1_q <= ux_q * vy_q;
			m2_q <= vx_q * uy_q;
		end
		if (emit_go) begin
			pend_q <= cur_tri;
		end
		if (out_load) begin
			out_q <= out_nxt;
		end
		if (state_q == S_SHIFT) begin
			shift_wa_s1 <= shift_k_q[IDX_W-1:0];
		end
	end

	assign res_valid = out_v_q;
	assign res       = out_q;

endmodule

[hw/rtl/petc_checker.sv]
// ----------------------------------------------------------------------------
// petc_checker
// Port-level checks of the polygon ear-clip triangulator, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polygon_ear_clip_triangulator_macros.svh"

module petc_checker import petc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic vtx_valid,
	input logic vtx_ready,
	input vtx_t vtx,
	input logic res_valid,
	input logic res_ready,
	input tri_t res
);

	// an empty-polygon result closes the polygon and carries no corners
	`PETC_ASSERT_NOW(a_empty_result, res_valid && !res.tri_valid, res.last_triangle && res.tri_ax == '0 && res.tri_ay == '0 && res.tri_bx == '0 && res.tri_by == '0 && res.tri_cx == '0 && res.tri_cy == '0, "empty result malformed")

	// closing vertex stops intake while the scan runs
	`PETC_ASSERT_NEXT(a_close_blocks, vtx_valid && vtx_ready && vtx.last_vertex, !vtx_ready, "vertex intake open during scan")

	// intake reopens only with the closing result in the output register
	`PETC_ASSERT_NOW(a_reopen_last, $rose(vtx_ready), res_valid && res.last_triangle, "intake reopened without final result")

	// stalled result holds
	`PETC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result changed under stall")

endmodule

bind polygon_ear_clip_triangulator petc_checker u_petc_checker (.*);

[sim/polygon_ear_clip_triangulator_tb.sv]
// ----------------------------------------------------------------------------
// polygon_ear_clip_triangulator_tb
// Feeds polygons into the ear-clip triangulator and checks every triangle.
//
// Each accepted vertex goes into a local ear-clipping predictor, which keeps
// its own copy of the vertex store and live list and queues the triangles a
// closed polygon should give. A checker compares each result transfer with
// the oldest queued triangle. Directed polygons cover the turn signs, the
// degenerate and empty cases, coordinate extremes and the capacity limit.
// Random polygons follow, mostly clockwise star shapes with reflex corners.
// Both sides idle at random, and once the result side holds off long enough
// to back the block up into its vertex input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polygon_ear_clip_triangulator_tb;
	import petc_pkg::*;

	localparam int  CYCLE_LIMIT  = 2_000_000;
	localparam int  DRAIN_CYCLES = 40;
	localparam int  RANDOM_ITEMS = 140;
	localparam real PI           = 3.14159265358979;

	logic clk;
	logic arst_n;
	logic vtx_valid;
	logic vtx_ready;
	vtx_t vtx;
	logic res_valid;
	logic res_ready;
	tri_t res;

	// predictor state
	coord_t vx_mem [MAX_VERTICES];
	coord_t vy_mem [MAX_VERTICES];
	int     order_mem [MAX_VERTICES];
	int     live_n;
	bit     ovf_seen;
	tri_t   expected_tris [$];

	coord_t poly_x [$];
	coord_t poly_y [$];

	int  mismatch_count;
	int  items_sent;
	int  cycle_count;
	int  hold_request;
	bit  burst_mode;

	polygon_ear_clip_triangulator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_ready (vtx_ready),
		.vtx       (vtx),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic bit clockwise_turn(coord_t ax, coord_t ay, coord_t bx, coord_t by,
			coord_t cx, coord_t cy);
		longint ux, uy, wx, wy;
		ux = longint'(bx) - longint'(ax);
		uy = longint'(by) - longint'(ay);
		wx = longint'(cx) - longint'(bx);
		wy = longint'(cy) - longint'(by);
		return (ux * wy - wx * uy) < 0;
	endfunction

	function automatic void predict_vertex(vtx_t v);
		int   cursor, pass_start, a, b, c, rm, k;
		bit   have_held, done;
		tri_t held, t;
		if (live_n < MAX_VERTICES) begin
			vx_mem[live_n]    = v.vertex_x;
			vy_mem[live_n]    = v.vertex_y;
			order_mem[live_n] = live_n;
			live_n++;
		end else begin
			ovf_seen = 1'b1;
		end
		if (!v.last_vertex)
			return;

		cursor     = 0;
		pass_start = live_n;
		have_held  = 1'b0;
		done       = 1'b0;
		held       = '0;
		while (live_n > 2 && !done) begin
			if (cursor >= live_n) begin
				cursor = 0;
				if (live_n == pass_start)
					done = 1'b1;
				pass_start = live_n;
			end
			if (!done) begin
				a = order_mem[cursor % live_n];
				b = order_mem[(cursor + 1) % live_n];
				c = order_mem[(cursor + 2) % live_n];
				if (clockwise_turn(vx_mem[a], vy_mem[a], vx_mem[b], vy_mem[b],
						vx_mem[c], vy_mem[c])) begin
					t               = '0;
					t.tri_ax        = vx_mem[a];
					t.tri_ay        = vy_mem[a];
					t.tri_bx        = vx_mem[b];
					t.tri_by        = vy_mem[b];
					t.tri_cx        = vx_mem[c];
					t.tri_cy        = vy_mem[c];
					t.tri_valid     = 1'b1;
					t.overflow      = ovf_seen;
					if (have_held)
						expected_tris = {expected_tris, held};
					held      = t;
					have_held = 1'b1;
					rm = (cursor + 1) % live_n;
					for (k = rm; k + 1 < live_n; k++)
						order_mem[k] = order_mem[k + 1];
					live_n--;
				end
				cursor++;
			end
		end

		// empty polygon: one result with no triangle
		if (!have_held) begin
			held          = '0;
			held.overflow = ovf_seen;
		end
		held.last_triangle = 1'b1;
		expected_tris = {expected_tris, held};

		live_n   = 0;
		ovf_seen = 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		if (burst_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	task automatic send_vertex(coord_t x, coord_t y, logic last);
		int   gap;
		vtx_t item;
		gap              = pick_gap();
		item.vertex_x    = x;
		item.vertex_y    = y;
		item.last_vertex = last;
		if (gap > 0) begin
			vtx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vtx_valid <= 1'b1;
		vtx       <= item;
		@(posedge clk);
		while (!vtx_ready) @(posedge clk);
		predict_vertex(item);
		items_sent++;
	endtask

	task automatic send_polygon();
		int k;
		for (k = 0; k < poly_x.size(); k++)
			send_vertex(poly_x[k], poly_y[k], k == poly_x.size() - 1);
	endtask

	task automatic add_point(coord_t x, coord_t y);
		poly_x = {poly_x, x};
		poly_y = {poly_y, y};
	endtask

	// star-shaped ring around a random center, radius jittered per vertex
	task automatic make_star(int n, bit clockwise);
		real cxr, cyr, rad, ang, step, rr;
		int  k;
		poly_x.delete();
		poly_y.delete();
		cxr  = $urandom_range(0, 32000) - 16000.0;
		cyr  = $urandom_range(0, 32000) - 16000.0;
		rad  = $urandom_range(16, 16000);
		ang  = $urandom_range(0, 359) * PI / 180.0;
		step = 2.0 * PI / n;
		for (k = 0; k < n; k++) begin
			rr = rad * ($urandom_range(30, 100) / 100.0);
			add_point(coord_t'(int'(cxr + rr * $cos(ang))), coord_t'(int'(cyr + rr * $sin(ang))));
			ang = clockwise ? ang - step : ang + step;
		end
	endtask

	task automatic make_random(int n);
		int k;
		poly_x.delete();
		poly_y.delete();
		for (k = 0; k < n; k++)
			add_point(coord_t'($urandom), coord_t'($urandom));
	endtask

	// points close to one line, with exact repeats now and then
	task automatic make_line(int n);
		int     k;
		coord_t x0, y0, dx, dy;
		poly_x.delete();
		poly_y.delete();
		x0 = coord_t'($urandom_range(0, 2000)) - 16'sd1000;
		y0 = coord_t'($urandom_range(0, 2000)) - 16'sd1000;
		dx = coord_t'($urandom_range(0, 64)) - 16'sd32;
		dy = coord_t'($urandom_range(0, 64)) - 16'sd32;
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 3) == 0 && k > 0)
				add_point(poly_x[k-1], poly_y[k-1]);
			else
				add_point(x0 + coord_t'(k) * dx + coord_t'($urandom_range(0, 2)) - 16'sd1,
					y0 + coord_t'(k) * dy);
		end
	endtask

	task automatic wait_drained();
		while (expected_tris.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_turn_signs();
		// clockwise triangle clips, counter-clockwise one gives nothing
		send_vertex(16'sd0, 16'sd0, 1'b0);
		send_vertex(16'sd0, 16'sd16, 1'b0);
		send_vertex(16'sd16, 16'sd0, 1'b1);
		send_vertex(16'sd0, 16'sd0, 1'b0);
		send_vertex(16'sd16, 16'sd0, 1'b0);
		send_vertex(16'sd0, 16'sd16, 1'b1);
	endtask

	task automatic test_degenerate();
		// collinear, lone vertex, pair
		send_vertex(16'sd0, 16'sd0, 1'b0);
		send_vertex(16'sd16, 16'sd16, 1'b0);
		send_vertex(16'sd32, 16'sd32, 1'b1);
		send_vertex(16'sd5, -16'sd5, 1'b1);
		send_vertex(16'sd100, 16'sd7, 1'b0);
		send_vertex(-16'sd100, 16'sd9, 1'b1);
	endtask

	task automatic test_coord_extremes();
		send_vertex(-16'sd32768, -16'sd32768, 1'b0);
		send_vertex(-16'sd32768, 16'sd32767, 1'b0);
		send_vertex(16'sd32767, -16'sd32768, 1'b1);
		send_vertex(16'sd32767, 16'sd32767, 1'b0);
		send_vertex(16'sd32767, -16'sd32768, 1'b0);
		send_vertex(-16'sd32768, 16'sd32767, 1'b1);
	endtask

	task automatic test_square_and_notch();
		send_vertex(16'sd0, 16'sd0, 1'b0);
		send_vertex(16'sd0, 16'sd160, 1'b0);
		send_vertex(16'sd160, 16'sd160, 1'b0);
		send_vertex(16'sd160, 16'sd0, 1'b1);
		// reflex corner, with the neighbour positions wrapping past the end of the live list
		send_vertex(16'sd0, 16'sd0, 1'b0);
		send_vertex(16'sd0, 16'sd64, 1'b0);
		send_vertex(16'sd32, 16'sd32, 1'b0);
		send_vertex(16'sd64, 16'sd64, 1'b0);
		send_vertex(16'sd64, 16'sd0, 1'b1);
	endtask

	task automatic test_capacity();
		// store filled exactly, then the closing vertex is dropped
		make_star(MAX_VERTICES + 1, 1'b1);
		send_polygon();
	endtask

	task automatic test_output_backpressure();
		int k;
		burst_mode   = 1'b1;
		hold_request = 600;
		for (k = 0; k < 6; k++) begin
			make_star($urandom_range(3, 6), 1'b1);
			send_polygon();
		end
		burst_mode = 1'b0;
	endtask

	task automatic test_random_polygons();
		int stop_at, kind, n;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			kind = $urandom_range(0, 99);
			n    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(3, 8);
			// stretches without any idling on either side
			burst_mode = ($urandom_range(0, 7) == 0);
			if (kind < 55)
				make_star(n, 1'b1);
			else if (kind < 70)
				make_random($urandom_range(3, 6));
			else if (kind < 80)
				make_star(n, 1'b0);
			else if (kind < 90)
				make_random($urandom_range(1, 2));
			else
				make_line(n);
			send_polygon();
		end
		burst_mode = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------
	initial begin
		int stall_left;
		stall_left = 0;
		res_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				stall_left   = hold_request;
				hold_request = 0;
			end else if (stall_left == 0 && !burst_mode && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				res_ready <= 1'b0;
				stall_left--;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	initial begin
		tri_t want;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && res_ready) begin
				if (expected_tris.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result transfer: a=(%0d,%0d) valid=%0b last=%0b",
							res.tri_ax, res.tri_ay, res.tri_valid, res.last_triangle);
				end else begin
					want = expected_tris.pop_front();
					if (res !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("mismatch exp: a=(%0d,%0d) b=(%0d,%0d) c=(%0d,%0d) v=%0b ovf=%0b last=%0b",
								want.tri_ax, want.tri_ay, want.tri_bx, want.tri_by,
								want.tri_cx, want.tri_cy, want.tri_valid, want.overflow,
								want.last_triangle);
							$display("         got: a=(%0d,%0d) b=(%0d,%0d) c=(%0d,%0d) v=%0b ovf=%0b last=%0b",
								res.tri_ax, res.tri_ay, res.tri_bx, res.tri_by,
								res.tri_cx, res.tri_cy, res.tri_valid, res.overflow,
								res.last_triangle);
						end
					end
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		live_n         = 0;
		ovf_seen       = 1'b0;
		mismatch_count = 0;
		items_sent     = 0;
		hold_request   = 0;
		burst_mode     = 1'b0;
		vtx_valid <= 1'b0;
		vtx       <= '0;
		arst_n    <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_turn_signs();
		test_degenerate();
		test_coord_extremes();
		test_square_and_notch();
		test_capacity();
		test_output_backpressure();
		test_random_polygons();

		vtx_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_tris.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/petc_pkg.sv
hw/rtl/petc_ram.sv
hw/rtl/polygon_ear_clip_triangulator.sv
hw/rtl/petc_checker.sv
sim/polygon_ear_clip_triangulator_tb.sv
